// File: rtl/leash_safety_alarm_fsm_macros.svh
// Assertion helpers for the leash safety alarm block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef LEASH_SAFETY_ALARM_FSM_MACROS_SVH
`define LEASH_SAFETY_ALARM_FSM_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LSA_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("lsa: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define LSA_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("lsa: next-cycle check failed");

`endif

// File: rtl/lsa_pkg.sv
package lsa_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WARN_TENSION    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_TENSION    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_PEAK_LIM  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_ALERT_HOLD  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_HOLD       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_WARN_LIM   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_DANGER_LIM = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN        = 4'd7;

  // Register reset values
  localparam logic [11:0] RST_WARN_TENSION    = 12'd192;
  localparam logic [11:0] RST_LOCK_TENSION    = 12'd320;
  localparam logic [9:0]  RST_ACCEL_PEAK_LIM  = 10'd115;
  localparam logic [15:0] RST_PRE_ALERT_HOLD  = 16'd180;
  localparam logic [15:0] RST_LOCK_HOLD       = 16'd1000;
  localparam logic [15:0] RST_DIST_WARN_LIM   = 16'd160;
  localparam logic [15:0] RST_DIST_DANGER_LIM = 16'd320;
  localparam logic [15:0] RST_COOLDOWN        = 16'd2000;

  // Event rate limits in ms
  localparam logic [31:0] BURST_GAP_MS    = 32'd500;
  localparam logic [31:0] DISTANCE_GAP_MS = 32'd3000;

  // Event codes and severities
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_BURST    = 2'd1;
  localparam logic [1:0] EV_DISTANCE = 2'd2;
  localparam logic [1:0] EV_FENCE    = 2'd3;
  localparam logic [1:0] SEV_NONE     = 2'd0;
  localparam logic [1:0] SEV_DISTANCE = 2'd2;
  localparam logic [1:0] SEV_BURST    = 2'd3;

  // Reported state codes
  localparam logic [2:0] CODE_SAFE     = 3'd0;
  localparam logic [2:0] CODE_WATCH    = 3'd1;
  localparam logic [2:0] CODE_PRE      = 3'd2;
  localparam logic [2:0] CODE_BURST    = 3'd3;
  localparam logic [2:0] CODE_LOCKED   = 3'd4;
  localparam logic [2:0] CODE_RECOVERY = 3'd5;
  localparam logic [2:0] CODE_DISTANCE = 3'd6;

  typedef enum logic [6:0] {
    ST_SAFE     = 7'b0000001,
    ST_WATCH    = 7'b0000010,
    ST_PRE      = 7'b0000100,
    ST_BURST    = 7'b0001000,
    ST_LOCKED   = 7'b0010000,
    ST_RECOVERY = 7'b0100000,
    ST_DISTANCE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [11:0] warn_tension;
    logic [11:0] lock_tension;
    logic [9:0]  accel_peak_limit;
    logic [15:0] pre_alert_hold;
    logic [15:0] lock_hold;
    logic [15:0] distance_warn_limit;
    logic [15:0] distance_danger_limit;
    logic [15:0] cooldown;
  } cfg_t;

  typedef struct packed {
    logic [11:0] tension;
    logic [11:0] tension_peak;
    logic [9:0]  accel_peak;
    logic [15:0] distance;
    logic        fence_breach;
    logic        running;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    state_t      state;
    logic        event_fire;
    logic [1:0]  event_type;
    logic [1:0]  event_severity;
    logic [11:0] event_tension_peak;
    logic [9:0]  event_accel_peak;
    logic [15:0] event_distance;
    logic [31:0] event_time;
  } step_t;

  // Map the one-hot state onto its reported code
  function automatic logic [2:0] state_code(input state_t st);
    logic [2:0] code;
    unique case (st)
      ST_SAFE:     code = CODE_SAFE;
      ST_WATCH:    code = CODE_WATCH;
      ST_PRE:      code = CODE_PRE;
      ST_BURST:    code = CODE_BURST;
      ST_LOCKED:   code = CODE_LOCKED;
      ST_RECOVERY: code = CODE_RECOVERY;
      ST_DISTANCE: code = CODE_DISTANCE;
      default:     code = CODE_SAFE;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/lsa_if.sv
// Sample request channel
interface lsa_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] tension;
  logic [11:0] tension_peak;
  logic [9:0]  accel_peak;
  logic [15:0] distance;
  logic        fence_breach;
  logic        running;
  logic [31:0] timestamp;

  modport source (output valid, tension, tension_peak, accel_peak, distance,
                  fence_breach, running, timestamp, input ready);
  modport sink   (input valid, tension, tension_peak, accel_peak, distance,
                  fence_breach, running, timestamp, output ready);
endinterface

// Result channel
interface lsa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  safety_state;
  logic [1:0]  event_type;
  logic [1:0]  event_severity;
  logic [11:0] event_tension_peak;
  logic [9:0]  event_accel_peak;
  logic [15:0] event_distance;
  logic [31:0] event_time;

  modport source (output valid, safety_state, event_type, event_severity,
                  event_tension_peak, event_accel_peak, event_distance,
                  event_time, input ready);
  modport sink   (input valid, safety_state, event_type, event_severity,
                  event_tension_peak, event_accel_peak, event_distance,
                  event_time, output ready);
endinterface

// Configuration write channel
interface lsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/lsa_cfg_regs.sv
module lsa_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [lsa_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lsa_pkg::CFG_DATA_W-1:0] wr_data,
  output lsa_pkg::cfg_t                cfg
);
  import lsa_pkg::*;

  cfg_t cfg_r;

  // Write one register per request, masked to its width; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warn_tension          <= RST_WARN_TENSION;
      cfg_r.lock_tension          <= RST_LOCK_TENSION;
      cfg_r.accel_peak_limit      <= RST_ACCEL_PEAK_LIM;
      cfg_r.pre_alert_hold        <= RST_PRE_ALERT_HOLD;
      cfg_r.lock_hold             <= RST_LOCK_HOLD;
      cfg_r.distance_warn_limit   <= RST_DIST_WARN_LIM;
      cfg_r.distance_danger_limit <= RST_DIST_DANGER_LIM;
      cfg_r.cooldown              <= RST_COOLDOWN;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_WARN_TENSION:    cfg_r.warn_tension          <= wr_data[11:0];
        REG_LOCK_TENSION:    cfg_r.lock_tension          <= wr_data[11:0];
        REG_ACCEL_PEAK_LIM:  cfg_r.accel_peak_limit      <= wr_data[9:0];
        REG_PRE_ALERT_HOLD:  cfg_r.pre_alert_hold        <= wr_data;
        REG_LOCK_HOLD:       cfg_r.lock_hold             <= wr_data;
        REG_DIST_WARN_LIM:   cfg_r.distance_warn_limit   <= wr_data;
        REG_DIST_DANGER_LIM: cfg_r.distance_danger_limit <= wr_data;
        REG_COOLDOWN:        cfg_r.cooldown              <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/lsa_step.sv
module lsa_step (
  input  lsa_pkg::cfg_t     cfg,
  input  lsa_pkg::in_item_t item,
  input  lsa_pkg::state_t   state,
  input  logic [31:0]       entry_time,
  input  logic [31:0]       last_event_time,
  output lsa_pkg::step_t    nxt
);
  import lsa_pkg::*;

  logic        t_watch;
  logic        burst;
  logic        d_danger;
  logic        d_warn;
  logic [31:0] in_state;
  logic [31:0] since_ev;

  // Threshold checks and wrapping elapsed times
  assign t_watch  = item.tension >= cfg.warn_tension;
  assign burst    = (item.tension_peak >= cfg.lock_tension) &&
                    (item.accel_peak >= cfg.accel_peak_limit);
  assign d_danger = (item.distance >= cfg.distance_danger_limit) || item.fence_breach;
  assign d_warn   = item.distance >= cfg.distance_warn_limit;
  assign in_state = item.timestamp - entry_time;
  assign since_ev = item.timestamp - last_event_time;

  // Decide next state and any rate-limited event
  always_comb begin
    nxt                    = '0;
    nxt.state              = state;
    nxt.event_type         = EV_NONE;
    nxt.event_severity     = SEV_NONE;
    unique case (state)
      ST_SAFE: begin
        if (d_danger) nxt.state = ST_DISTANCE;
        else if (t_watch || item.running) nxt.state = ST_WATCH;
      end
      ST_WATCH: begin
        if (burst) nxt.state = ST_BURST;
        else if (d_danger) nxt.state = ST_DISTANCE;
        else if (t_watch && (in_state >= {16'd0, cfg.pre_alert_hold})) nxt.state = ST_PRE;
        else if (!t_watch && !d_warn) nxt.state = ST_SAFE;
      end
      ST_PRE: begin
        if (burst) nxt.state = ST_BURST;
        else if (!t_watch) nxt.state = ST_SAFE;
      end
      ST_BURST: begin
        if (since_ev > BURST_GAP_MS) begin
          nxt.event_fire         = 1'b1;
          nxt.event_type         = EV_BURST;
          nxt.event_severity     = SEV_BURST;
          nxt.event_tension_peak = item.tension_peak;
          nxt.event_accel_peak   = item.accel_peak;
          nxt.event_distance     = item.distance;
          nxt.event_time         = item.timestamp;
        end
        nxt.state = ST_LOCKED;
      end
      ST_LOCKED: begin
        if ((in_state >= {16'd0, cfg.lock_hold}) && !t_watch) nxt.state = ST_RECOVERY;
      end
      ST_RECOVERY: begin
        if (in_state >= {16'd0, cfg.cooldown}) nxt.state = ST_SAFE;
      end
      ST_DISTANCE: begin
        if (since_ev > DISTANCE_GAP_MS) begin
          nxt.event_fire     = 1'b1;
          nxt.event_type     = item.fence_breach ? EV_FENCE : EV_DISTANCE;
          nxt.event_severity = SEV_DISTANCE;
          nxt.event_distance = item.distance;
          nxt.event_time     = item.timestamp;
        end
        if (!d_danger && !d_warn) nxt.state = ST_SAFE;
      end
      default: nxt.state = ST_SAFE;
    endcase
  end

endmodule

// File: rtl/leash_safety_alarm_fsm.sv
// Leash safety alarm state machine.
// in_ch carries one sensor sample per request (tension, peak tension, peak
// acceleration, distance, fence and running flags, ms timestamp); out_ch
// returns exactly one result per sample: the new safety state and an event,
// which is zero in every field when none fires. cfg_ch writes one of eight
// threshold and hold registers per request; indexes 8 and up are ignored.
// cfg_ch is always ready; write it only while no sample is in flight.
// Flow: an accepted sample is held in the input register, where the state
// machine evaluates it, and moves into the result register once that has
// room; its result is offered on out_ch from there.
// Throughput: one sample per cycle while out_ch does not stall; the state
// registers feed back through next-state logic, so samples follow directly.
// When out_ch stalls, the result register holds and the input register can
// still take one more sample; in_ch drops ready only once both are full.
// Reset puts the machine in safe, clears the entry and last-event times,
// restores register defaults and empties both pipeline registers.
module leash_safety_alarm_fsm (
  input logic       clk,
  input logic       rst_n,
  lsa_in_if.sink    in_ch,
  lsa_out_if.source out_ch,
  lsa_cfg_if.sink   cfg_ch
);
  import lsa_pkg::*;

  cfg_t        cfg;
  in_item_t    in_r;
  logic        in_vld_r;
  step_t       nxt;
  state_t      state_r;
  logic [31:0] entry_time_r;
  logic [31:0] last_ev_r;
  logic        out_vld_r;
  step_t       out_r;
  logic        adv;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  lsa_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // Advance the held sample into the result register when it has room
  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  // Capture an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.tension      <= in_ch.tension;
      in_r.tension_peak <= in_ch.tension_peak;
      in_r.accel_peak   <= in_ch.accel_peak;
      in_r.distance     <= in_ch.distance;
      in_r.fence_breach <= in_ch.fence_breach;
      in_r.running      <= in_ch.running;
      in_r.timestamp    <= in_ch.timestamp;
    end
  end

  lsa_step u_step (
    .cfg             (cfg),
    .item            (in_r),
    .state           (state_r),
    .entry_time      (entry_time_r),
    .last_event_time (last_ev_r),
    .nxt             (nxt)
  );

  // Update machine state as the sample retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SAFE;
      entry_time_r <= '0;
      last_ev_r    <= '0;
    end else if (adv) begin
      state_r <= nxt.state;
      if (nxt.state != state_r) entry_time_r <= in_r.timestamp;
      if (nxt.event_fire) last_ev_r <= in_r.timestamp;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= nxt;
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.safety_state       = state_code(out_r.state);
  assign out_ch.event_type         = out_r.event_type;
  assign out_ch.event_severity     = out_r.event_severity;
  assign out_ch.event_tension_peak = out_r.event_tension_peak;
  assign out_ch.event_accel_peak   = out_r.event_accel_peak;
  assign out_ch.event_distance     = out_r.event_distance;
  assign out_ch.event_time         = out_r.event_time;

  // Checks
`include "leash_safety_alarm_fsm_macros.svh"

  `LSA_ASSERT_NXT(a_burst_to_locked, adv && (state_r == ST_BURST), state_r == ST_LOCKED)
  `LSA_ASSERT_NXT(a_event_marks_time, adv && nxt.event_fire, last_ev_r == out_r.event_time)
  `LSA_ASSERT_NXT(a_stalled_item_kept, in_vld_r && out_vld_r && !out_ch.ready, in_vld_r)
  `LSA_ASSERT_IMP(a_out_matches_state, out_vld_r && in_vld_r && !adv, out_r.state == state_r)

endmodule
